FILE: rtl/bbs_pkg.sv
// package: shared constants for the blum blum shub key byte generator
package bbs_pkg;

	// default width of the modulus, the seed and the running value
	localparam int DEFAULT_MOD_WIDTH = 20;

	// number of generated bits in one key byte
	localparam int BITS_PER_BYTE = 8;

	// configuration port index width and register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEED    = 2'd1;

	// register values after reset
	localparam int MODULUS_RESET = 2;
	localparam int SEED_RESET    = 1;

endpackage

FILE: rtl/bbs_key_byte_generator.sv
// top level: blum blum shub key byte generator with a bit-serial modular squarer
//
// Usage: each input transaction (in_valid/in_ready) requests one key byte; new_key
// set restarts the sequence from seed squared mod modulus before the byte is made.
// The result transaction (out_valid/out_ready) carries key_byte, first bit in bit 0.
// Registers modulus (index 0) and seed (index 1) are written through cfg_we,
// cfg_index, cfg_data; users must do so only while the block is idle; not enforced.
//
// Operation: the operand is first reduced mod modulus, one bit a cycle, then
// squared by an interleaved shift-add modular multiplier that takes one
// multiplier bit a cycle. A byte takes one reduction pass and one squaring
// per key bit, plus one more squaring when new_key is set, all done by that
// one squaring unit. One item is in work at a time; in_ready is high only while
// no item is in work.
//
// Reset: arst_n clears the running value to zero, sets modulus to 2 and seed to 1,
// and empties the output register. If the receiver stalls, the finished byte waits
// in the output register and a new request is still taken; its result then waits
// in the unit until the output register is free.
module bbs_key_byte_generator #(
	parameter int MOD_WIDTH = bbs_pkg::DEFAULT_MOD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          cfg_we,
	input  logic [bbs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [MOD_WIDTH-1:0]          cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          new_key,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bbs_pkg::BITS_PER_BYTE-1:0] key_byte
);

	localparam int CNT_W = $clog2(MOD_WIDTH);
	localparam int BIT_W = $clog2(bbs_pkg::BITS_PER_BYTE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_WIDTH - 1);
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(bbs_pkg::BITS_PER_BYTE - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RED  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                          state_q;
	logic [MOD_WIDTH-1:0]                modulus_q;
	logic [MOD_WIDTH-1:0]                seed_q;
	logic [MOD_WIDTH-1:0]                x_q;
	logic [MOD_WIDTH-1:0]                sh_q;
	logic [MOD_WIDTH-1:0]                a_q;
	logic [MOD_WIDTH-1:0]                r_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [BIT_W-1:0]                    bit_cnt_q;
	logic                                seed_ph_q;
	logic [bbs_pkg::BITS_PER_BYTE-1:0]   byte_q;
	logic                                out_valid_q;
	logic [bbs_pkg::BITS_PER_BYTE-1:0]   key_byte_q;

	logic                                mod_zero;
	logic                                in_acc;
	logic                                out_free;
	logic [MOD_WIDTH:0]                  red_t;
	logic [MOD_WIDTH-1:0]                red_next;
	logic [MOD_WIDTH:0]                  dbl_t;
	logic [MOD_WIDTH-1:0]                dbl_r;
	logic [MOD_WIDTH:0]                  add_t;
	logic [MOD_WIDTH-1:0]                mul_next;
	logic [MOD_WIDTH-1:0]                sq_res;

	assign mod_zero  = (modulus_q == '0);
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign key_byte  = key_byte_q;

	// reduction step: shift in one operand bit, subtract modulus once
	always_comb begin
		red_t = {r_q, sh_q[MOD_WIDTH-1]};
		if (red_t >= {1'b0, modulus_q}) begin
			red_t = red_t - {1'b0, modulus_q};
		end
		red_next = red_t[MOD_WIDTH-1:0];
	end

	// multiply step: double mod n, then add the multiplicand if the bit is set
	always_comb begin
		dbl_t = {r_q, 1'b0};
		if (dbl_t >= {1'b0, modulus_q}) begin
			dbl_t = dbl_t - {1'b0, modulus_q};
		end
		dbl_r = dbl_t[MOD_WIDTH-1:0];
		add_t = {1'b0, dbl_r} + (sh_q[MOD_WIDTH-1] ? {1'b0, a_q} : '0);
		if (add_t >= {1'b0, modulus_q}) begin
			add_t = add_t - {1'b0, modulus_q};
		end
		mul_next = add_t[MOD_WIDTH-1:0];
		sq_res   = mod_zero ? '0 : mul_next;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_WIDTH'(bbs_pkg::MODULUS_RESET);
			seed_q    <= MOD_WIDTH'(bbs_pkg::SEED_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				bbs_pkg::CFG_MODULUS: modulus_q <= cfg_data;
				bbs_pkg::CFG_SEED:    seed_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and bit-serial datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			x_q       <= '0;
			sh_q      <= '0;
			a_q       <= '0;
			byte_q    <= '0;
			cnt_q     <= '0;
			bit_cnt_q <= '0;
			seed_ph_q <= 1'b0;
			r_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sh_q      <= new_key ? seed_q : x_q;
						r_q       <= '0;
						cnt_q     <= CNT_LAST;
						bit_cnt_q <= '0;
						seed_ph_q <= new_key;
						state_q   <= ST_RED;
					end
				end
				ST_RED: begin
					if (cnt_q == '0) begin
						a_q     <= red_next;
						sh_q    <= red_next;
						r_q     <= '0;
						cnt_q   <= CNT_LAST;
						state_q <= ST_MUL;
					end else begin
						sh_q  <= {sh_q[MOD_WIDTH-2:0], 1'b0};
						r_q   <= red_next;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						a_q   <= sq_res;
						sh_q  <= sq_res;
						r_q   <= '0;
						cnt_q <= CNT_LAST;
						if (seed_ph_q) begin
							seed_ph_q <= 1'b0;
						end else begin
							byte_q    <= {sq_res[0], byte_q[bbs_pkg::BITS_PER_BYTE-1:1]};
							bit_cnt_q <= bit_cnt_q + 1'b1;
							if (bit_cnt_q == BIT_LAST) begin
								x_q     <= sq_res;
								state_q <= ST_DONE;
							end
						end
					end else begin
						sh_q  <= {sh_q[MOD_WIDTH-2:0], 1'b0};
						r_q   <= mul_next;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			key_byte_q  <= '0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
			key_byte_q  <= byte_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	// an accepted request always starts with the reduction pass
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_RED)
		else $error("request accepted without starting reduction");

	// reduction remainder stays below a nonzero modulus
	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED && !mod_zero) |-> r_q < modulus_q)
		else $error("reduction remainder out of range");

	// multiplier accumulator and multiplicand stay below a nonzero modulus
	a_mul_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && !mod_zero) |-> (r_q < modulus_q && a_q < modulus_q))
		else $error("multiplier operand out of range");

	// a finished byte waits while the output register is still held
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> state_q == ST_DONE)
		else $error("finished byte dropped while output stalled");
`endif

endmodule
